// ===== sv/ajdd_pkg.sv =====
// package for the anim-j delta decoder: widths, phase codes, result kinds and result word type
package ajdd_pkg;

	localparam int ADDR_W   = 24;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);
	localparam int MAX_PLN  = 8;
	localparam int OUT_DW   = 40;

	typedef enum logic [7:0] {
		PH_OPMODE = 8'b0000_0001,
		PH_XOR    = 8'b0000_0010,
		PH_HEIGHT = 8'b0000_0100,
		PH_WIDTH  = 8'b0000_1000,
		PH_COUNT  = 8'b0001_0000,
		PH_OFFSET = 8'b0010_0000,
		PH_DATA   = 8'b0100_0000,
		PH_PAD    = 8'b1000_0000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_END   = 2'd1,
		KIND_BAD   = 2'd2,
		KIND_SHORT = 2'd3
	} kind_t;

	localparam logic [15:0] OP_END  = 16'd0;
	localparam logic [15:0] OP_COL  = 16'd1;
	localparam logic [15:0] OP_AREA = 16'd2;

	localparam logic REG_ROW_PITCH   = 1'b0;
	localparam logic REG_PLANE_COUNT = 1'b1;

	typedef struct packed {
		kind_t             kind;
		logic [2:0]        plane;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
		logic              xr;
		logic              last;
	} res_t;

endpackage

// ===== sv/anim_j_delta_decoder_core.sv =====
// anim-j delta decoder: parses a delta chunk byte stream into bitplane write words
//
//  channel   | dir | words                  | contents
//  ----------+-----+------------------------+-------------------------------------------
//  s_axis    | in  | one per chunk byte     | tdata data_byte, tlast last_byte
//  m_axis    | out | 0 to 2 per input word  | tdata plane/addr/data/xor, tuser kind,
//            |     |                        | tlast last result of its input word
//  apb       | in  | register writes/reads  | 0x0 row_pitch, 0x4 plane_count
//
//  one input word per cycle: the parser state and the result words for a byte
//  are formed in the cycle the byte is taken and land in a four-entry result queue
//  s_axis_tready drops while fewer than two entries are free; with m_axis ready the
//  queue never holds more than two, so only a stalled m_axis holds off the input
//  arst_n clears parser state, queue pointers and the registers (pitch 40, planes 5)
//  after an end opmode, bad opmode or chunk end, input words are taken and dropped
module anim_j_delta_decoder_core
	import ajdd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// input stream
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,   // [7:0] data_byte
	input  logic               s_axis_tlast,   // last_byte
	// result stream
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [OUT_DW-1:0]  m_axis_tdata,   // [2:0] plane_index, [26:3] write_address,
	                                           // [34:27] write_data, [35] xor_with_source,
	                                           // [39:36] zero
	output logic [1:0]         m_axis_tuser,   // [1:0] result_kind
	output logic               m_axis_tlast,   // last_result
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	// configuration registers
	logic [12:0] row_pitch_q;
	logic [3:0]  plane_count_q;

	// parser state
	phase_t            phase_q, phase_d;
	logic [7:0]        hi_q, hi_d;
	logic              bow_q, bow_d;
	logic [1:0]        mode_q, mode_d;
	logic              xor_q, xor_d;
	logic [15:0]       height_q, height_d;
	logic [15:0]       width_q, width_d;
	logic [15:0]       ops_q, ops_d;
	logic [15:0]       offset_q, offset_d;
	logic [15:0]       row_q, row_d;
	logic [2:0]        pln_q, pln_d;
	logic [15:0]       col_q, col_d;
	logic [ADDR_W-1:0] base_q, base_d;
	logic              odd_q, odd_d;
	logic              fin_q, fin_d;

	// result queue
	res_t              q_mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	// per-byte results
	logic              main_v, end_v;
	res_t              main_r, end_r;

	logic              take, pop;
	logic [3:0]        depth;
	logic [15:0]       word;
	logic [15:0]       ops_dec;
	phase_t            done_phase;

	// apb: always ready, index from address bit 2
	assign pready = 1'b1;
	always_comb begin
		unique case (paddr[2])
			REG_ROW_PITCH:   prdata = {19'd0, row_pitch_q};
			REG_PLANE_COUNT: prdata = {28'd0, plane_count_q};
			default:         prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pitch_q   <= 13'd40;
			plane_count_q <= 4'd5;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_ROW_PITCH) begin
				row_pitch_q <= pwdata[12:0];
			end else begin
				plane_count_q <= pwdata[3:0];
			end
		end
	end

	// handshakes
	assign s_axis_tready = (cnt_q <= QCNT_W'(QDEPTH - 2));
	assign take          = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (cnt_q != '0);
	assign pop           = m_axis_tvalid && m_axis_tready;

	// planes above eight act as eight
	assign depth   = (plane_count_q > 4'(MAX_PLN)) ? 4'(MAX_PLN) : plane_count_q;
	assign word    = {hi_q, s_axis_tdata};
	assign ops_dec = ops_q - 16'd1;
	// where the parser goes when an operation finishes
	assign done_phase = (ops_dec == 16'd0) ? (odd_q ? PH_PAD : PH_OPMODE) : PH_OFFSET;

	// next state and results for the byte on s_axis
	always_comb begin
		phase_d  = phase_q;
		hi_d     = hi_q;
		bow_d    = bow_q;
		mode_d   = mode_q;
		xor_d    = xor_q;
		height_d = height_q;
		width_d  = width_q;
		ops_d    = ops_q;
		offset_d = offset_q;
		row_d    = row_q;
		pln_d    = pln_q;
		col_d    = col_q;
		base_d   = base_q;
		odd_d    = odd_q;
		fin_d    = fin_q;

		main_v = 1'b0;
		main_r = '{kind: KIND_WRITE, plane: pln_q, addr: base_q + ADDR_W'(col_q),
			data: s_axis_tdata, xr: xor_q, last: 1'b0};

		unique case (phase_q)
			PH_DATA: begin
				main_v = 1'b1;
				if (({1'b0, col_q} + 17'd1) >= {1'b0, width_q}) begin
					col_d = 16'd0;
					if (({1'b0, pln_q} + 4'd1) >= depth) begin
						pln_d  = 3'd0;
						base_d = base_q + ADDR_W'(row_pitch_q);
						if (({1'b0, row_q} + 17'd1) >= {1'b0, height_q}) begin
							row_d   = 16'd0;
							ops_d   = ops_dec;
							phase_d = done_phase;
						end else begin
							row_d = row_q + 16'd1;
						end
					end else begin
						pln_d = pln_q + 3'd1;
					end
				end else begin
					col_d = col_q + 16'd1;
				end
			end
			PH_PAD: begin
				phase_d = PH_OPMODE;
			end
			default: begin
				if (!bow_q) begin
					hi_d  = s_axis_tdata;
					bow_d = 1'b1;
				end else begin
					bow_d = 1'b0;
					unique case (phase_q)
						PH_OPMODE: begin
							if (word == OP_COL || word == OP_AREA) begin
								mode_d  = word[1:0];
								phase_d = PH_XOR;
							end else begin
								// end opmode or unknown opmode closes the delta
								fin_d       = 1'b1;
								main_v      = 1'b1;
								main_r      = '0;
								main_r.kind = (word == OP_END) ? KIND_END : KIND_BAD;
							end
						end
						PH_XOR: begin
							xor_d   = (word != 16'd0);
							phase_d = PH_HEIGHT;
						end
						PH_HEIGHT: begin
							height_d = word;
							if (mode_q == OP_COL[1:0]) begin
								// column mode: one byte wide
								width_d = 16'd1;
								phase_d = PH_COUNT;
							end else begin
								phase_d = PH_WIDTH;
							end
						end
						PH_WIDTH: begin
							width_d = word;
							phase_d = PH_COUNT;
						end
						PH_COUNT: begin
							ops_d = word;
							odd_d = word[0] & height_q[0] & width_q[0] & depth[0];
							// zero count: group ends here, parity is zero so no pad
							phase_d = (word == 16'd0) ? PH_OPMODE : PH_OFFSET;
						end
						default: begin
							// offset word starts an operation
							offset_d = word;
							base_d   = ADDR_W'(word);
							row_d    = 16'd0;
							pln_d    = 3'd0;
							col_d    = 16'd0;
							if (height_q == 16'd0 || width_q == 16'd0 || depth == 4'd0) begin
								// empty operation
								ops_d   = ops_dec;
								phase_d = done_phase;
							end else begin
								phase_d = PH_DATA;
							end
						end
					endcase
				end
			end
		endcase

		// chunk ran out before the delta closed
		end_v = s_axis_tlast && !fin_d;
		end_r = '0;
		end_r.kind = KIND_SHORT;
		end_r.last = 1'b1;
		if (end_v) begin
			fin_d = 1'b1;
		end
		main_r.last = !end_v;
	end

	// parser registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_OPMODE;
			hi_q     <= 8'd0;
			bow_q    <= 1'b0;
			mode_q   <= 2'd0;
			xor_q    <= 1'b0;
			height_q <= 16'd0;
			width_q  <= 16'd0;
			ops_q    <= 16'd0;
			offset_q <= 16'd0;
			row_q    <= 16'd0;
			pln_q    <= 3'd0;
			col_q    <= 16'd0;
			base_q   <= '0;
			odd_q    <= 1'b0;
			fin_q    <= 1'b0;
		end else if (take && !fin_q) begin
			phase_q  <= phase_d;
			hi_q     <= hi_d;
			bow_q    <= bow_d;
			mode_q   <= mode_d;
			xor_q    <= xor_d;
			height_q <= height_d;
			width_q  <= width_d;
			ops_q    <= ops_d;
			offset_q <= offset_d;
			row_q    <= row_d;
			pln_q    <= pln_d;
			col_q    <= col_d;
			base_q   <= base_d;
			odd_q    <= odd_d;
			fin_q    <= fin_d;
		end
	end

	// result queue: up to two pushes, one pop per cycle
	logic              push_any;
	logic [1:0]        push_n;
	logic [QPTR_W-1:0] wr_ptr_p1;

	assign push_any  = take && !fin_q;
	assign push_n    = push_any ? ({1'b0, main_v} + {1'b0, end_v}) : 2'd0;
	assign wr_ptr_p1 = wr_ptr_q + QPTR_W'(1);

	always_ff @(posedge clk) begin
		if (push_any) begin
			if (main_v) begin
				q_mem[wr_ptr_q] <= main_r;
				if (end_v) begin
					q_mem[wr_ptr_p1] <= end_r;
				end
			end else if (end_v) begin
				q_mem[wr_ptr_q] <= end_r;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(push_n) - QCNT_W'(pop);
		end
	end

	// output word from the queue head
	res_t head;
	assign head = q_mem[rd_ptr_q];
	assign m_axis_tdata = {4'd0, head.xr, head.data, head.addr, head.plane};
	assign m_axis_tuser = head.kind;
	assign m_axis_tlast = head.last;

endmodule
